// File: src/imu_rd_pkg.sv
// Shared types, status codes and constants of the inertial sensor bus reader.
// Used by imu_rd_conv and i2c_imu_init_and_burst_reader_unit; depends on nothing.
package imu_rd_pkg;

  // Sizes of the init sequence and of the burst.
  localparam int unsigned INIT_PAIRS   = 14;
  localparam int unsigned SAMPLE_BYTES = 14;
  localparam int unsigned SAMPLE_WORDS = SAMPLE_BYTES / 2;
  localparam logic [3:0]  PAIRS_MAX    = 4'(INIT_PAIRS - 1);
  localparam logic [3:0]  BYTES_LAST   = 4'(SAMPLE_BYTES - 1);
  localparam logic [2:0]  LAST_CHAN    = 3'(SAMPLE_WORDS - 1);

  // Conversion datapath widths.
  localparam int unsigned VAL_W     = 19;  // result width
  localparam int unsigned NUM_W     = 26;  // signed scaled numerator
  localparam int unsigned MAG_W     = 25;  // numerator magnitude
  localparam int unsigned DIV_W     = 12;  // divisor width
  localparam int unsigned REC_W     = 21;  // reciprocal and scale operand width
  localparam int unsigned MUL_W     = MAG_W + REC_W;
  // Reciprocals are floor(2^25 / divisor); 2^25 exceeds every magnitude, so the
  // estimated quotient is short by at most one.
  localparam int unsigned REC_SHIFT = 25;

  // Bus controller status codes (status byte divided by eight).
  localparam logic [4:0] STAT_START     = 5'd1;
  localparam logic [4:0] STAT_RSTART    = 5'd2;
  localparam logic [4:0] STAT_SLAW_ACK  = 5'd3;
  localparam logic [4:0] STAT_SLAW_NACK = 5'd4;
  localparam logic [4:0] STAT_DATA_ACK  = 5'd5;
  localparam logic [4:0] STAT_DATA_NACK = 5'd6;
  localparam logic [4:0] STAT_SLAR_ACK  = 5'd8;
  localparam logic [4:0] STAT_SLAR_NACK = 5'd9;
  localparam logic [4:0] STAT_RX_ACK    = 5'd10;
  localparam logic [4:0] STAT_RX_NACK   = 5'd11;
  localparam logic [4:0] STAT_IDLE      = 5'd31;

  // Control bits to clear.
  localparam logic [3:0] CLR_ACK   = 4'b0001;
  localparam logic [3:0] CLR_STOP  = 4'b0010;
  localparam logic [3:0] CLR_START = 4'b0100;
  localparam logic [3:0] CLR_IRQ   = 4'b1000;

  // Activity pin actions.
  localparam logic [1:0] PIN_KEEP = 2'd0;
  localparam logic [1:0] PIN_HIGH = 2'd1;
  localparam logic [1:0] PIN_LOW  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEV_ADDR   = 2'd0;
  localparam logic [1:0] CFG_FIRST_REG  = 2'd1;
  localparam logic [1:0] CFG_PAIRS_LAST = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_CONV,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    CV_IDLE,
    CV_MUL,
    CV_ABS,
    CV_RECIP,
    CV_BACK,
    CV_FIX,
    CV_DONE
  } conv_state_e;

  typedef struct packed {
    logic       start;
    logic [2:0] chan;
  } conv_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] value;
  } conv_rsp_t;

  // Packed so that the first field lands in the highest bits.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [2:0]              channel;
    logic [1:0]              activity_pin;
    logic [3:0]              clear_mask;
    logic                    set_ack;
    logic                    set_stop;
    logic                    set_start;
    logic [7:0]              tx_byte;
    logic                    tx_load;
  } out_data_t;

  typedef struct packed {
    logic      last;
    logic      sample_valid;
    out_data_t data;
  } out_item_t;

  // Init register pairs: even index is the register, odd index the value.
  // Pairs past the table read as zero bytes.
  function automatic logic [7:0] init_byte(logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h6B;
      5'd2:    b = 8'h19;
      5'd3:    b = 8'h07;
      5'd4:    b = 8'h1A;
      5'd6:    b = 8'h1B;
      5'd8:    b = 8'h1C;
      5'd10:   b = 8'h23;
      5'd12:   b = 8'h24;
      5'd14:   b = 8'h37;
      5'd16:   b = 8'h38;
      5'd17:   b = 8'h01;
      5'd18:   b = 8'h67;
      5'd20:   b = 8'h68;
      5'd22:   b = 8'h6A;
      5'd24:   b = 8'h6C;
      5'd26:   b = 8'h74;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Scale, offset and divisor per channel: accel 125v/2048,
  // temperature (50v+621010)/17, gyro 1000v/131.
  function automatic logic [REC_W-1:0] conv_mul(logic [2:0] chan);
    logic [REC_W-1:0] m;
    if (chan < 3'd3) m = REC_W'(125);
    else if (chan == 3'd3) m = REC_W'(50);
    else m = REC_W'(1000);
    return m;
  endfunction

  function automatic logic signed [NUM_W-1:0] conv_add(logic [2:0] chan);
    logic signed [NUM_W-1:0] a;
    if (chan == 3'd3) a = NUM_W'(621010);
    else a = '0;
    return a;
  endfunction

  function automatic logic [DIV_W-1:0] conv_div(logic [2:0] chan);
    logic [DIV_W-1:0] d;
    if (chan < 3'd3) d = DIV_W'(2048);
    else if (chan == 3'd3) d = DIV_W'(17);
    else d = DIV_W'(131);
    return d;
  endfunction

  function automatic logic [REC_W-1:0] conv_rec(logic [2:0] chan);
    logic [REC_W-1:0] r;
    if (chan < 3'd3) r = REC_W'(16384);
    else if (chan == 3'd3) r = REC_W'(1973790);
    else r = REC_W'(256140);
    return r;
  endfunction

endpackage

// File: src/imu_rd_conv.sv
// Conversion unit: one shared multiplier scales the sample, then divides by reciprocal
// multiplication with a back-multiply and a single correction step.
// Depends on imu_rd_pkg for widths, request/response structs and channel constants.
module imu_rd_conv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imu_rd_pkg::conv_req_t req_i,
  input  logic [15:0]           word_i,
  output imu_rd_pkg::conv_rsp_t rsp_o
);
  import imu_rd_pkg::*;

  conv_state_e             state_q, state_d;
  logic [15:0]             word_q;
  logic [2:0]              chan_q;
  logic [15:0]             word_abs;
  logic [MAG_W-1:0]        prod_q;
  logic signed [NUM_W-1:0] prod_s;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_neg;
  logic                    neg_q;
  logic [MAG_W-1:0]        mag_q;
  logic [VAL_W-1:0]        quo_q;
  logic [MAG_W-1:0]        rem_q;
  logic [MAG_W-1:0]        mul_a;
  logic [REC_W-1:0]        mul_b;
  logic [MUL_W-1:0]        mul_p;
  logic [DIV_W-1:0]        divisor;
  logic                    fits;

  assign word_abs = word_q[15] ? 16'(-word_q) : word_q;
  assign prod_s   = signed'({1'b0, prod_q});
  assign num      = (word_q[15] ? -prod_s : prod_s) + conv_add(chan_q);
  assign num_neg  = NUM_W'(-num);
  assign divisor  = conv_div(chan_q);
  // The estimate is at most one short, so one compare finishes the quotient.
  assign fits     = rem_q >= MAG_W'(divisor);

  // Operand select of the shared multiplier.
  always_comb begin
    case (state_q)
      CV_RECIP: begin
        mul_a = mag_q;
        mul_b = conv_rec(chan_q);
      end
      CV_BACK: begin
        mul_a = MAG_W'(quo_q);
        mul_b = REC_W'(divisor);
      end
      default: begin
        mul_a = MAG_W'(word_abs);
        mul_b = conv_mul(chan_q);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign rsp_o.value = neg_q ? signed'(VAL_W'(~quo_q + VAL_W'(1))) : signed'(quo_q);
  assign rsp_o.done  = (state_q == CV_DONE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      CV_IDLE:  if (req_i.start) state_d = CV_MUL;
      CV_MUL:   state_d = CV_ABS;
      CV_ABS:   state_d = CV_RECIP;
      CV_RECIP: state_d = CV_BACK;
      CV_BACK:  state_d = CV_FIX;
      CV_FIX:   state_d = CV_DONE;
      CV_DONE:  state_d = CV_IDLE;
      default:  state_d = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      CV_IDLE: begin
        if (req_i.start) begin
          word_q <= word_i;
          chan_q <= req_i.chan;
        end
      end
      CV_MUL: prod_q <= mul_p[MAG_W-1:0];
      CV_ABS: begin
        neg_q <= num[NUM_W-1];
        mag_q <= num[NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
      end
      CV_RECIP: quo_q <= mul_p[REC_SHIFT +: VAL_W];
      CV_BACK:  rem_q <= mag_q - mul_p[MAG_W-1:0];
      CV_FIX:   quo_q <= quo_q + VAL_W'(fits);
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == CV_IDLE)
    else $error("conversion requested while the unit is busy");

  a_done_after_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CV_DONE |-> $past(state_q) == CV_FIX)
    else $error("conversion finished without the quotient correction");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CV_FIX |-> rem_q < (MAG_W'(divisor) << 1))
    else $error("quotient estimate more than one short");
`endif

endmodule

// File: src/i2c_imu_init_and_burst_reader_unit.sv
// Top level of the polled inertial sensor bus reader: poll decoder, sample store,
// conversion sequencer and output register. Depends on imu_rd_pkg and imu_rd_conv.
//
// Channel   Direction  Handshake            Payload
// s_axis    in         tvalid/tready        tdata: status_code, rx_byte
// m_axis    out        tvalid/tready        tdata: bus actions, channel, value;
//                                           tuser: sample_valid; tlast: last
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An ordinary poll yields one transfer on m_axis.
// A completion poll yields seven transfers in channel order, each after a store read,
// request, six steps of the shared multiply unit and an output load that waits on m_axis.
// No poll is taken while a completion is in progress or the output register is held.
// Reset restores the configuration defaults and restarts the init sequence.
module i2c_imu_init_and_burst_reader_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [4:0] status_code, [12:5] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] tx_load, [8:1] tx_byte, [9] set_start, [10] set_stop, [11] set_ack,
  // [15:12] clear_mask, [17:16] activity_pin, [20:18] channel, [39:21] value
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // [0] sample_valid
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import imu_rd_pkg::*;

  // Configuration registers.
  logic [6:0] dev_addr_q;
  logic [7:0] first_reg_q;
  logic [3:0] pairs_last_q;

  // Sequencer state.
  logic       init_done_q, init_done_d;
  logic [3:0] pairs_written_q, pairs_written_d;
  logic [1:0] write_phase_q, write_phase_d;
  logic [3:0] bytes_read_q, bytes_read_d;
  logic [3:0] byte_index_q, byte_index_d;

  ctrl_state_e state_q, state_d;
  logic [2:0]  k_q, k_d;

  // Sample store, split into high (even) and low (odd) bytes of each word.
  logic [7:0]  hi_mem [SAMPLE_WORDS];
  logic [7:0]  lo_mem [SAMPLE_WORDS];
  logic [15:0] word_q;
  logic        store_we;

  logic [4:0]  code;
  logic [7:0]  rx;
  logic        in_acc;
  logic        complete;
  logic        out_free;
  logic        out_valid_q;
  out_item_t   out_q, out_d;
  logic        out_load;
  out_data_t   poll;
  logic [3:0]  pairs_lim;
  logic [1:0]  phase_sat;
  logic [3:0]  bytes_inc;
  conv_req_t   conv_req;
  conv_rsp_t   conv_rsp;

  assign code      = s_axis_tdata_i[4:0];
  assign rx        = s_axis_tdata_i[12:5];
  assign complete  = init_done_q && (bytes_read_q > BYTES_LAST);
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;

  assign pairs_lim = (pairs_last_q > PAIRS_MAX) ? PAIRS_MAX : pairs_last_q;
  assign phase_sat = (write_phase_q == 2'd3) ? 2'd3 : write_phase_q + 2'd1;
  assign bytes_inc = bytes_read_q + 4'd1;

  // Bus actions and state updates of one ordinary poll.
  always_comb begin
    poll            = '0;
    init_done_d     = init_done_q;
    pairs_written_d = pairs_written_q;
    write_phase_d   = write_phase_q;
    bytes_read_d    = bytes_read_q;
    byte_index_d    = byte_index_q;
    store_we        = 1'b0;
    if (!init_done_q) begin
      case (code)
        STAT_START: begin
          write_phase_d   = 2'd0;
          poll.tx_load    = 1'b1;
          poll.tx_byte    = {dev_addr_q, 1'b0};
          poll.clear_mask = CLR_START;
          poll.set_ack    = 1'b1;
        end
        STAT_SLAW_ACK: begin
          write_phase_d = phase_sat;
          poll.tx_load  = 1'b1;
          poll.tx_byte  = init_byte({pairs_written_q, 1'b0});
        end
        STAT_SLAW_NACK, STAT_DATA_NACK: begin
          poll.set_stop = 1'b1;
          poll.set_ack  = 1'b1;
        end
        STAT_DATA_ACK: begin
          write_phase_d = phase_sat;
          poll.tx_load  = 1'b1;
          poll.tx_byte  = init_byte({pairs_written_q, 1'b1});
          // The pair is done only when the phase steps from two to three.
          if (write_phase_q == 2'd2) begin
            poll.set_start = 1'b1;
            if (pairs_written_q < pairs_lim) pairs_written_d = pairs_written_q + 4'd1;
            else init_done_d = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      poll.activity_pin = PIN_HIGH;
      case (code)
        STAT_START, STAT_RSTART: begin
          poll.tx_load    = 1'b1;
          poll.tx_byte    = {dev_addr_q, code == STAT_RSTART};
          poll.clear_mask = CLR_START;
          poll.set_ack    = 1'b1;
        end
        STAT_SLAW_ACK: begin
          poll.tx_load = 1'b1;
          poll.tx_byte = first_reg_q;
        end
        STAT_SLAW_NACK, STAT_DATA_NACK: begin
          poll.set_stop = 1'b1;
          poll.set_ack  = 1'b1;
        end
        STAT_DATA_ACK, STAT_SLAR_NACK: poll.set_start = 1'b1;
        STAT_SLAR_ACK: poll.set_ack = 1'b1;
        STAT_RX_ACK: begin
          store_we     = byte_index_q < 4'(SAMPLE_BYTES);
          byte_index_d = byte_index_q + 4'd1;
          bytes_read_d = bytes_inc;
          // Dropping the acknowledge before the final byte makes it the last one.
          if (bytes_inc == BYTES_LAST) poll.clear_mask = CLR_ACK | CLR_STOP | CLR_START | CLR_IRQ;
        end
        STAT_RX_NACK: begin
          store_we      = byte_index_q < 4'(SAMPLE_BYTES);
          byte_index_d  = '0;
          bytes_read_d  = bytes_inc;
          poll.set_stop = 1'b1;
          poll.set_ack  = 1'b1;
        end
        default: ;
      endcase
    end
    if (code != STAT_IDLE) poll.clear_mask = poll.clear_mask | CLR_IRQ;
  end

  // Sequencer: ordinary polls go straight to the output register; a completion poll
  // walks the seven channels through the shared conversion unit.
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    out_load = 1'b0;
    out_d    = '0;
    conv_req = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (complete) begin
            state_d = ST_READ;
            k_d     = '0;
          end else begin
            out_load   = 1'b1;
            out_d.data = poll;
            out_d.last = 1'b1;
          end
        end
      end
      ST_READ:  state_d = ST_START;
      ST_START: begin
        conv_req.start = 1'b1;
        conv_req.chan  = k_q;
        state_d        = ST_CONV;
      end
      ST_CONV:  if (conv_rsp.done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          out_load                = 1'b1;
          out_d.sample_valid      = 1'b1;
          out_d.last              = (k_q == LAST_CHAN);
          out_d.data.channel      = k_q;
          out_d.data.value        = conv_rsp.value;
          out_d.data.set_start    = (k_q == '0);
          out_d.data.activity_pin = (k_q == '0) ? PIN_LOW : PIN_KEEP;
          if (k_q == LAST_CHAN) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 3'd1;
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      k_q             <= '0;
      out_valid_q     <= 1'b0;
      dev_addr_q      <= 7'd104;
      first_reg_q     <= 8'd59;
      pairs_last_q    <= 4'd13;
      init_done_q     <= 1'b0;
      pairs_written_q <= '0;
      write_phase_q   <= '0;
      bytes_read_q    <= '0;
      byte_index_q    <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_DEV_ADDR:   dev_addr_q   <= cfg_data_i[6:0];
          CFG_FIRST_REG:  first_reg_q  <= cfg_data_i;
          CFG_PAIRS_LAST: pairs_last_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (complete) begin
          bytes_read_q <= '0;
        end else begin
          init_done_q     <= init_done_d;
          pairs_written_q <= pairs_written_d;
          write_phase_q   <= write_phase_d;
          bytes_read_q    <= bytes_read_d;
          byte_index_q    <= byte_index_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !complete && store_we) begin
      if (byte_index_q[0]) lo_mem[byte_index_q[3:1]] <= rx;
      else hi_mem[byte_index_q[3:1]] <= rx;
    end
    if (state_q == ST_READ) word_q <= {hi_mem[k_q], lo_mem[k_q]};
  end

  imu_rd_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (conv_req),
    .word_i (word_q),
    .rsp_o  (conv_rsp)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.data;
  assign m_axis_tuser_o  = out_q.sample_valid;
  assign m_axis_tlast_o  = out_q.last;

`ifndef NO_ASSERTIONS
  a_pairs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pairs_written_q <= PAIRS_MAX)
    else $error("init pair counter ran past the table");

  a_no_read_before_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done_q |-> bytes_read_q == '0)
    else $error("bytes counted before initialization finished");

  a_complete_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && complete |=> state_q == ST_READ && k_q == '0 && bytes_read_q == '0)
    else $error("completion poll did not start the conversion walk");

  a_last_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.sample_valid && out_q.last |-> out_q.data.channel == LAST_CHAN)
    else $error("conversion burst ended on the wrong channel");
`endif

endmodule
